// ----- sv/opt_pkg.sv -----
// shared constants, types and helpers for the online perceptron trainer
package opt_pkg;

	// datapath geometry
	localparam int N_FEATURES   = 4;
	localparam int WEIGHT_WIDTH = 24;
	localparam int FEAT_WIDTH   = 16;
	localparam int LR_WIDTH     = 16;
	localparam int FRAC_SHIFT   = 12;

	localparam logic [LR_WIDTH-1:0] LR_RESET = LR_WIDTH'(655);

	// product and accumulator widths
	localparam int PROD_W = WEIGHT_WIDTH + FEAT_WIDTH;
	localparam int ACC_W  = PROD_W + $clog2(N_FEATURES + 1) + 1;
	localparam int LRP_W  = LR_WIDTH + 1 + FEAT_WIDTH;
	localparam int STEP_W = LRP_W + 1;
	localparam int UPD_W  = ((WEIGHT_WIDTH > STEP_W) ? WEIGHT_WIDTH : STEP_W) + 1;

	// register file layout
	localparam int DATA_W     = 32;
	localparam int N_REGS     = N_FEATURES + 2;
	localparam int CFG_ADDR_W = $clog2(4 * N_REGS);
	localparam int REG_IDX_W  = CFG_ADDR_W - 2;

	localparam int REG_LEARNING_RATE = 0;
	localparam int REG_WEIGHT_BASE   = 1;
	localparam int REG_BIAS          = N_FEATURES + 1;

	// request operations
	typedef enum logic [1:0] {
		OP_INFER  = 2'd0,
		OP_TRAIN  = 2'd1,
		OP_RELOAD = 2'd2
	} op_t;

	localparam logic signed [WEIGHT_WIDTH-1:0] W_MAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
	localparam logic signed [WEIGHT_WIDTH-1:0] W_MIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};

	// clamp a widened update back into the signed weight range
	function automatic logic signed [WEIGHT_WIDTH-1:0] sat_w(input logic signed [UPD_W-1:0] v);
		logic signed [UPD_W-1:0] hi;
		logic signed [UPD_W-1:0] lo;
		hi = UPD_W'(W_MAX);
		lo = UPD_W'(W_MIN);
		if (v > hi) begin
			return W_MAX;
		end else if (v < lo) begin
			return W_MIN;
		end
		return WEIGHT_WIDTH'(v);
	endfunction

endpackage

// ----- sv/online_perceptron_trainer_unit.sv -----
// top level of the online perceptron trainer: register file, datapath and handshakes
//
// Single perceptron with online learning. Each request carries four signed Q4.12
// features, a 0/1 label and an operation (infer, infer and train, reload). The
// block answers every request with one result: prediction is 1 when the weighted
// sum of the Q8.16 weights plus the bias is strictly above zero, and error_flag is
// 1 when prediction differs from label (reload answers 0 and 0). A training
// request moves each weight by learning_rate * feature * (label - prediction),
// floored to Q8.16, and the bias by learning_rate * (label - prediction); both
// saturate at 24 signed bits. Reload copies initial_weight_* and initial_bias into
// the live weights. One request is taken every clock cycle while the result
// channel is not stalled; an accepted request is held in the input register and
// then written to the result register, from which the output presents it.
// Between the input register and the result register sits a single combinational
// pass: eight multipliers, the adder tree, the sign test and the saturating weight
// update, so the updated weights are already in place for the request that
// follows. Configuration sits behind an APB-style port at byte address 4*i;
// writes are meant for idle periods.
module online_perceptron_trainer_unit (
	input  logic                             clk,
	input  logic                             arst_n,

	// request channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       operation,
	input  logic signed [15:0]               feature_0,
	input  logic signed [15:0]               feature_1,
	input  logic signed [15:0]               feature_2,
	input  logic signed [15:0]               feature_3,
	input  logic                             label,

	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             prediction,
	output logic                             error_flag,

	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [opt_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [opt_pkg::DATA_W-1:0]       pwdata,
	output logic [opt_pkg::DATA_W-1:0]       prdata,
	output logic                             pready
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [opt_pkg::LR_WIDTH-1:0]            lr_q;
	logic signed [opt_pkg::WEIGHT_WIDTH-1:0] init_w_q [opt_pkg::N_FEATURES];
	logic signed [opt_pkg::WEIGHT_WIDTH-1:0] init_b_q;

	logic                                    cfg_wr;
	logic [opt_pkg::REG_IDX_W-1:0]           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	// word index, byte offset bits are ignored
	assign cfg_idx = paddr[opt_pkg::CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q     <= opt_pkg::LR_RESET;
			init_b_q <= '0;
			for (int i = 0; i < opt_pkg::N_FEATURES; i++) begin
				init_w_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			if (cfg_idx == opt_pkg::REG_IDX_W'(opt_pkg::REG_LEARNING_RATE)) begin
				lr_q <= pwdata[opt_pkg::LR_WIDTH-1:0];
			end
			for (int i = 0; i < opt_pkg::N_FEATURES; i++) begin
				if (cfg_idx == opt_pkg::REG_IDX_W'(opt_pkg::REG_WEIGHT_BASE + i)) begin
					init_w_q[i] <= pwdata[opt_pkg::WEIGHT_WIDTH-1:0];
				end
			end
			if (cfg_idx == opt_pkg::REG_IDX_W'(opt_pkg::REG_BIAS)) begin
				init_b_q <= pwdata[opt_pkg::WEIGHT_WIDTH-1:0];
			end
			// indexes past the last register fall through untouched
		end
	end

	// read mux, weights read back sign extended
	always_comb begin
		prdata = '0;
		if (cfg_idx == opt_pkg::REG_IDX_W'(opt_pkg::REG_LEARNING_RATE)) begin
			prdata = opt_pkg::DATA_W'(lr_q);
		end
		for (int i = 0; i < opt_pkg::N_FEATURES; i++) begin
			if (cfg_idx == opt_pkg::REG_IDX_W'(opt_pkg::REG_WEIGHT_BASE + i)) begin
				prdata = opt_pkg::DATA_W'(init_w_q[i]);
			end
		end
		if (cfg_idx == opt_pkg::REG_IDX_W'(opt_pkg::REG_BIAS)) begin
			prdata = opt_pkg::DATA_W'(init_b_q);
		end
	end

	// ------------------------------------------------------------------
	// input register
	// ------------------------------------------------------------------
	logic                                    valid_s1;
	logic [1:0]                              op_s1;
	logic signed [opt_pkg::FEAT_WIDTH-1:0]   feat_s1 [opt_pkg::N_FEATURES];
	logic                                    label_s1;

	logic signed [opt_pkg::FEAT_WIDTH-1:0]   feat_in [opt_pkg::N_FEATURES];
	logic                                    in_take;
	logic                                    advance;
	logic                                    out_valid_q;

	assign feat_in[0] = feature_0;
	assign feat_in[1] = feature_1;
	assign feat_in[2] = feature_2;
	assign feat_in[3] = feature_3;

	// the held request moves on when the result register is empty or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1    <= operation;
			label_s1 <= label;
			for (int i = 0; i < opt_pkg::N_FEATURES; i++) begin
				feat_s1[i] <= feat_in[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// live weights and bias
	// ------------------------------------------------------------------
	logic signed [opt_pkg::WEIGHT_WIDTH-1:0] weights_q [opt_pkg::N_FEATURES];
	logic signed [opt_pkg::WEIGHT_WIDTH-1:0] bias_q;

	// ------------------------------------------------------------------
	// forward pass: sum of w*x at Q.28 plus bias scaled by 2^12
	// ------------------------------------------------------------------
	logic signed [opt_pkg::PROD_W-1:0]       prod [opt_pkg::N_FEATURES];
	logic signed [opt_pkg::ACC_W-1:0]        acc;
	logic                                    pred;

	always_comb begin
		for (int i = 0; i < opt_pkg::N_FEATURES; i++) begin
			prod[i] = weights_q[i] * feat_s1[i];
		end
	end

	always_comb begin
		logic signed [opt_pkg::ACC_W-1:0] sum;
		sum = opt_pkg::ACC_W'(bias_q) <<< opt_pkg::FRAC_SHIFT;
		for (int i = 0; i < opt_pkg::N_FEATURES; i++) begin
			sum = sum + opt_pkg::ACC_W'(prod[i]);
		end
		acc = sum;
	end

	// strictly positive
	assign pred = !acc[opt_pkg::ACC_W-1] && (acc != '0);

	// ------------------------------------------------------------------
	// learning step
	// ------------------------------------------------------------------
	logic                                    diff_pos;
	logic                                    diff_neg;
	logic signed [opt_pkg::LR_WIDTH:0]       lr_sx;
	logic signed [opt_pkg::LRP_W-1:0]        lrp [opt_pkg::N_FEATURES];
	logic signed [opt_pkg::WEIGHT_WIDTH-1:0] w_next [opt_pkg::N_FEATURES];
	logic signed [opt_pkg::WEIGHT_WIDTH-1:0] b_next;

	// prediction minus label is +1, -1 or 0
	assign diff_pos = pred && !label_s1;
	assign diff_neg = !pred && label_s1;
	assign lr_sx    = signed'({1'b0, lr_q});

	always_comb begin
		for (int i = 0; i < opt_pkg::N_FEATURES; i++) begin
			lrp[i] = lr_sx * feat_s1[i];
		end
	end

	always_comb begin
		logic signed [opt_pkg::STEP_W-1:0] step;
		logic signed [opt_pkg::STEP_W-1:0] step_fl;
		logic signed [opt_pkg::UPD_W-1:0]  bstep;
		for (int i = 0; i < opt_pkg::N_FEATURES; i++) begin
			step = '0;
			if (diff_pos) begin
				step = opt_pkg::STEP_W'(lrp[i]);
			end else if (diff_neg) begin
				step = -opt_pkg::STEP_W'(lrp[i]);
			end
			// arithmetic shift floors toward minus infinity
			step_fl   = step >>> opt_pkg::FRAC_SHIFT;
			w_next[i] = opt_pkg::sat_w(opt_pkg::UPD_W'(weights_q[i]) - opt_pkg::UPD_W'(step_fl));
		end
		bstep = '0;
		if (diff_pos) begin
			bstep = opt_pkg::UPD_W'(lr_sx);
		end else if (diff_neg) begin
			bstep = -opt_pkg::UPD_W'(lr_sx);
		end
		b_next = opt_pkg::sat_w(opt_pkg::UPD_W'(bias_q) - bstep);
	end

	// state moves exactly when the held request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			for (int i = 0; i < opt_pkg::N_FEATURES; i++) begin
				weights_q[i] <= '0;
			end
		end else if (advance) begin
			case (opt_pkg::op_t'(op_s1))
				opt_pkg::OP_RELOAD: begin
					bias_q <= init_b_q;
					for (int i = 0; i < opt_pkg::N_FEATURES; i++) begin
						weights_q[i] <= init_w_q[i];
					end
				end
				opt_pkg::OP_TRAIN: begin
					bias_q <= b_next;
					for (int i = 0; i < opt_pkg::N_FEATURES; i++) begin
						weights_q[i] <= w_next[i];
					end
				end
				default: begin
					// infer and the unused code leave the state alone
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	logic                                    pred_q;
	logic                                    err_q;
	logic                                    res_pred;
	logic                                    res_err;

	always_comb begin
		case (opt_pkg::op_t'(op_s1))
			opt_pkg::OP_RELOAD: begin
				res_pred = 1'b0;
				res_err  = 1'b0;
			end
			default: begin
				res_pred = pred;
				res_err  = pred ^ label_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pred_q <= res_pred;
			err_q  <= res_err;
		end
	end

	assign out_valid  = out_valid_q;
	assign prediction = pred_q;
	assign error_flag = err_q;

endmodule

// ----- sv/opt_checker.sv -----
// port-level checks for the online perceptron trainer, bound to the top level
module opt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             prediction,
	input logic                             error_flag,
	input logic                             psel,
	input logic [opt_pkg::CFG_ADDR_W-1:0]   paddr,
	input logic [opt_pkg::DATA_W-1:0]       prdata,
	input logic                             pready
);

	// a stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(prediction) && $stable(error_flag))
		else $error("result payload changed while stalled");

	// an accepted request reaches the result register once the output is not stalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("accepted request did not produce a result");

	// learning rate reads back zero extended
	a_lr_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && pready
			&& paddr[opt_pkg::CFG_ADDR_W-1:2]
				== opt_pkg::REG_IDX_W'(opt_pkg::REG_LEARNING_RATE)
		|-> prdata[opt_pkg::DATA_W-1:opt_pkg::LR_WIDTH] == '0)
		else $error("learning rate readback has upper bits set");

endmodule

bind online_perceptron_trainer_unit opt_checker u_opt_checker (.*);
